@@ sv/cv3_pkg.sv @@
// ---------------------------------------------------------------------------
// cv3_pkg: shared types and constants of the 3x3 convolution block
// Field widths, request codes, the micro-op encoding and the control store
// that sequences one partial-sum request.
// ---------------------------------------------------------------------------
package cv3_pkg;

  localparam int CMD_W       = 2;
  localparam int POS_W       = 10;
  localparam int DATA_W      = 32;
  localparam int SIDE_W      = 6;
  localparam int KERNEL_SIDE = 3;
  localparam int TAP_COUNT   = KERNEL_SIDE * KERNEL_SIDE;
  localparam int TAP_W       = $clog2(TAP_COUNT);
  localparam int ADDR_W      = 12;
  localparam int STEP_W      = 5;
  localparam int MIN_SIDE    = 3;

  // Request codes carried on the command field.
  localparam logic [CMD_W-1:0] CMD_LOAD_TAP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_PIX = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PSUM     = 2'd2;

  // Micro-operations of the sequencer.
  typedef enum logic [2:0] {
    U_IDLE,
    U_CHECK,
    U_DIV,
    U_READ,
    U_WAIT,
    U_FIN
  } uop_t;

  // Neighbor offset along one axis.
  typedef enum logic [1:0] {
    OFF_ZERO,
    OFF_NEG,
    OFF_POS
  } off_t;

  // One control word of the program.
  typedef struct packed {
    uop_t             op;
    logic [TAP_W-1:0] tap;
    off_t             drow;
    off_t             dcol;
  } ucode_t;

  // Conditions the datapath reports to the sequencer.
  typedef struct packed {
    logic start;
    logic outside;
    logic out_busy;
  } cond_t;

  // Program layout.
  localparam logic [STEP_W-1:0] STEP_IDLE  = 5'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK = 5'd1;
  localparam logic [STEP_W-1:0] STEP_DIV0  = 5'd2;
  localparam logic [STEP_W-1:0] STEP_READ0 = 5'd12;
  localparam logic [STEP_W-1:0] STEP_WAIT0 = 5'd21;
  localparam logic [STEP_W-1:0] STEP_FIN   = 5'd23;

  function automatic ucode_t uword(uop_t op, logic [TAP_W-1:0] tap, off_t dr, off_t dc);
    ucode_t w;
    w.op   = op;
    w.tap  = tap;
    w.drow = dr;
    w.dcol = dc;
    return w;
  endfunction

  // Control store: one word per step.
  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
    ucode_t w;
    w = uword(U_IDLE, '0, OFF_ZERO, OFF_ZERO);
    unique case (step)
      5'd0:  w = uword(U_IDLE,  4'd0, OFF_ZERO, OFF_ZERO);
      5'd1:  w = uword(U_CHECK, 4'd0, OFF_ZERO, OFF_ZERO);
      5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
      5'd7, 5'd8, 5'd9, 5'd10, 5'd11:
             w = uword(U_DIV,   4'd0, OFF_ZERO, OFF_ZERO);
      5'd12: w = uword(U_READ,  4'd0, OFF_NEG,  OFF_NEG);
      5'd13: w = uword(U_READ,  4'd1, OFF_NEG,  OFF_ZERO);
      5'd14: w = uword(U_READ,  4'd2, OFF_NEG,  OFF_POS);
      5'd15: w = uword(U_READ,  4'd3, OFF_ZERO, OFF_NEG);
      5'd16: w = uword(U_READ,  4'd4, OFF_ZERO, OFF_ZERO);
      5'd17: w = uword(U_READ,  4'd5, OFF_ZERO, OFF_POS);
      5'd18: w = uword(U_READ,  4'd6, OFF_POS,  OFF_NEG);
      5'd19: w = uword(U_READ,  4'd7, OFF_POS,  OFF_ZERO);
      5'd20: w = uword(U_READ,  4'd8, OFF_POS,  OFF_POS);
      5'd21, 5'd22:
             w = uword(U_WAIT,  4'd0, OFF_ZERO, OFF_ZERO);
      5'd23: w = uword(U_FIN,   4'd0, OFF_ZERO, OFF_ZERO);
      default: w = uword(U_IDLE, 4'd0, OFF_ZERO, OFF_ZERO);
    endcase
    return w;
  endfunction

endpackage

@@ sv/cv3_if.sv @@
// ---------------------------------------------------------------------------
// cv3 channel interfaces
// Valid/ready channels for requests, results and the side register write.
// ---------------------------------------------------------------------------
interface cv3_in_if;
  logic                            valid;
  logic                            ready;
  logic [cv3_pkg::CMD_W-1:0]       command;
  logic [cv3_pkg::POS_W-1:0]       position;
  logic signed [cv3_pkg::DATA_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

interface cv3_out_if;
  logic                            valid;
  logic                            ready;
  logic [cv3_pkg::POS_W-1:0]       out_position;
  logic signed [cv3_pkg::DATA_W-1:0] out_value;

  modport source (output valid, out_position, out_value, input ready);
  modport sink   (input valid, out_position, out_value, output ready);
endinterface

interface cv3_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cv3_pkg::SIDE_W-1:0]  map_side;

  modport source (output valid, map_side, input ready);
  modport sink   (input valid, map_side, output ready);
endinterface

@@ sv/conv3x3_same_zero_pad_top.sv @@
// ---------------------------------------------------------------------------
// conv3x3_same_zero_pad_top: 3x3 same-size convolution with zero padding
// Loads kernel taps and feature pixels, then answers partial-sum requests
// with the partial sum plus the 3x3 neighborhood dot product.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries requests: command 0 loads a kernel tap at position 0..8,
//   command 1 loads a feature pixel at position row*side+col, command 2
//   asks for the convolution at that position added to value. Command 3
//   is dropped. Only command 2 produces a result on out_ch.
//   cfg_ch writes the map side; it is always ready and should be written
//   while no request is in flight. Sides below 3 or above MAX_SIDE clamp.
//   After a load or a dropped request in_ch stays ready. A partial-sum request
//   keeps in_ch not ready through one check step, ten restoring-division
//   steps for row and column, nine reads from the single-port feature
//   memory feeding one multiply-accumulate per cycle, two drain steps and
//   the result step; only then is in_ch ready again. Outside the map the
//   check jumps to the result step. The result register is loaded when
//   the result step finds it free; the next request is taken while the
//   result waits.
//   If out_ch stalls, a second partial sum waits in its result step until
//   the register is free. Reset clears the sequencer and the result valid
//   and sets the side to 3; taps and pixels must be loaded before use.
// ---------------------------------------------------------------------------
module conv3x3_same_zero_pad_top #(
  parameter int MAX_SIDE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  cv3_in_if.sink            in_ch,
  cv3_out_if.source         out_ch,
  cv3_cfg_if.sink           cfg_ch
);

  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int MEM_DEPTH   = (STORE_DEPTH < 1024) ? STORE_DEPTH : 1024;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);

  cv3_pkg::ucode_t ucw;
  cv3_pkg::cond_t  cond;

  logic                          in_acc;
  logic [cv3_pkg::SIDE_W-1:0]    side_r;
  logic [cv3_pkg::DATA_W-1:0]    taps_r [cv3_pkg::TAP_COUNT];
  logic [cv3_pkg::DATA_W-1:0]    mem [MEM_DEPTH];
  logic [cv3_pkg::POS_W-1:0]     pos_r;
  logic [cv3_pkg::DATA_W-1:0]    acc_r;
  logic [cv3_pkg::POS_W-1:0]     dq_r;
  logic [cv3_pkg::SIDE_W-1:0]    rem_r;
  logic                          v1_r;
  logic                          v2_r;
  logic [cv3_pkg::DATA_W-1:0]    tap1_r;
  logic [cv3_pkg::DATA_W-1:0]    rdata_r;
  logic [cv3_pkg::DATA_W-1:0]    prod_r;
  logic                          out_valid_r;
  logic [cv3_pkg::POS_W-1:0]     out_pos_r;
  logic [cv3_pkg::DATA_W-1:0]    out_val_r;

  logic [2*cv3_pkg::SIDE_W-1:0]  side_sq;
  logic [cv3_pkg::SIDE_W:0]      rem_t;
  logic                          div_ge;
  logic [cv3_pkg::SIDE_W-1:0]    row;
  logic                          nb_ok;
  logic [cv3_pkg::ADDR_W-1:0]    rd_addr;
  logic                          mem_we;
  logic                          tap_we;
  logic [cv3_pkg::SIDE_W-1:0]    side_clamped;

  // Sequencer.
  cv3_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ucw   (ucw)
  );

  // Handshakes and sequencer conditions.
  assign in_ch.ready   = (ucw.op == cv3_pkg::U_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign side_sq       = (2*cv3_pkg::SIDE_W)'(side_r) * (2*cv3_pkg::SIDE_W)'(side_r);
  assign cond.start    = in_acc && (in_ch.command == cv3_pkg::CMD_PSUM);
  assign cond.outside  = (2*cv3_pkg::SIDE_W)'(pos_r) >= side_sq;
  assign cond.out_busy = out_valid_r && !out_ch.ready;

  // Side register, clamped to the supported range on write.
  always_comb begin
    side_clamped = cfg_ch.map_side;
    if (int'(cfg_ch.map_side) < cv3_pkg::MIN_SIDE) begin
      side_clamped = cv3_pkg::SIDE_W'(cv3_pkg::MIN_SIDE);
    end else if (int'(cfg_ch.map_side) > MAX_SIDE) begin
      side_clamped = cv3_pkg::SIDE_W'(MAX_SIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= cv3_pkg::SIDE_W'(cv3_pkg::MIN_SIDE);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      side_r <= side_clamped;
    end
  end

  // Kernel tap registers.
  assign tap_we = in_acc && (in_ch.command == cv3_pkg::CMD_LOAD_TAP)
                  && (int'(in_ch.position) < cv3_pkg::TAP_COUNT);

  always_ff @(posedge clk) begin
    if (tap_we) begin
      taps_r[in_ch.position[cv3_pkg::TAP_W-1:0]] <= in_ch.value;
    end
  end

  // Neighbor address and bounds for the current read step.
  assign row = dq_r[cv3_pkg::SIDE_W-1:0];

  always_comb begin
    rd_addr = cv3_pkg::ADDR_W'(pos_r);
    nb_ok   = 1'b1;
    case (ucw.drow)
      cv3_pkg::OFF_NEG: begin
        rd_addr = rd_addr - cv3_pkg::ADDR_W'(side_r);
        nb_ok   = nb_ok && (row != '0);
      end
      cv3_pkg::OFF_POS: begin
        rd_addr = rd_addr + cv3_pkg::ADDR_W'(side_r);
        nb_ok   = nb_ok && (({1'b0, row} + 7'd1) < {1'b0, side_r});
      end
      default: begin
        rd_addr = rd_addr;
      end
    endcase
    case (ucw.dcol)
      cv3_pkg::OFF_NEG: begin
        rd_addr = rd_addr - 12'd1;
        nb_ok   = nb_ok && (rem_r != '0);
      end
      cv3_pkg::OFF_POS: begin
        rd_addr = rd_addr + 12'd1;
        nb_ok   = nb_ok && (({1'b0, rem_r} + 7'd1) < {1'b0, side_r});
      end
      default: begin
        rd_addr = rd_addr;
      end
    endcase
    nb_ok = nb_ok && (int'(rd_addr) < STORE_DEPTH);
  end

  // Feature memory: one port, written by pixel loads, read by read steps.
  assign mem_we = in_acc && (in_ch.command == cv3_pkg::CMD_LOAD_PIX)
                  && (int'(in_ch.position) < STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_ch.position[MEM_AW-1:0]] <= in_ch.value;
    end else if (ucw.op == cv3_pkg::U_READ) begin
      rdata_r <= mem[rd_addr[MEM_AW-1:0]];
    end
  end

  // One restoring-division step.
  assign rem_t  = {rem_r, dq_r[cv3_pkg::POS_W-1]};
  assign div_ge = rem_t >= {1'b0, side_r};

  // Datapath registers: position, division, tap select, product, sum.
  always_ff @(posedge clk) begin
    if (cond.start) begin
      pos_r <= in_ch.position;
    end
    if (ucw.op == cv3_pkg::U_CHECK) begin
      dq_r  <= pos_r;
      rem_r <= '0;
    end else if (ucw.op == cv3_pkg::U_DIV) begin
      dq_r  <= {dq_r[cv3_pkg::POS_W-2:0], div_ge};
      rem_r <= div_ge ? cv3_pkg::SIDE_W'(rem_t - {1'b0, side_r})
                      : rem_t[cv3_pkg::SIDE_W-1:0];
    end
    if (ucw.op == cv3_pkg::U_READ) begin
      tap1_r <= taps_r[ucw.tap];
    end
    prod_r <= rdata_r * tap1_r;
    if (cond.start) begin
      acc_r <= in_ch.value;
    end else if (v2_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  // Pipeline valid flags for the multiply-accumulate path.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= (ucw.op == cv3_pkg::U_READ) && nb_ok;
      v2_r <= v1_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ucw.op == cv3_pkg::U_FIN) && !cond.out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ucw.op == cv3_pkg::U_FIN) && !cond.out_busy) begin
      out_pos_r <= pos_r;
      out_val_r <= acc_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_position = out_pos_r;
  assign out_ch.out_value    = out_val_r;

endmodule

@@ sv/cv3_useq.sv @@
// ---------------------------------------------------------------------------
// cv3_useq: micro-sequencer
// Step counter over the control store with conditional jumps for request
// start, the out-of-map shortcut and the result register hold.
// ---------------------------------------------------------------------------
module cv3_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  cv3_pkg::cond_t  cond,
  output cv3_pkg::ucode_t ucw
);

  logic [cv3_pkg::STEP_W-1:0] step_r;
  logic [cv3_pkg::STEP_W-1:0] step_nxt;

  // Step register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= cv3_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Fetch the control word and pick the next step.
  always_comb begin
    ucw      = cv3_pkg::ucode_rom(step_r);
    step_nxt = step_r + 5'd1;
    unique case (ucw.op)
      cv3_pkg::U_IDLE: begin
        step_nxt = cond.start ? cv3_pkg::STEP_CHECK : cv3_pkg::STEP_IDLE;
      end
      cv3_pkg::U_CHECK: begin
        step_nxt = cond.outside ? cv3_pkg::STEP_FIN : step_r + 5'd1;
      end
      cv3_pkg::U_FIN: begin
        step_nxt = cond.out_busy ? step_r : cv3_pkg::STEP_IDLE;
      end
      default: begin
        step_nxt = step_r + 5'd1;
      end
    endcase
  end

endmodule

@@ sv/cv3_chk.sv @@
// ---------------------------------------------------------------------------
// cv3_chk: port-level checks for the convolution block
// Watches the request and result channels over time; bound to the top.
// ---------------------------------------------------------------------------
module cv3_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [cv3_pkg::CMD_W-1:0]         in_command,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [cv3_pkg::POS_W-1:0]         out_position,
  input logic signed [cv3_pkg::DATA_W-1:0] out_value
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position) && $stable(out_value))
    else $error("result changed while stalled");

  // Loads and dropped requests leave the block ready.
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command != cv3_pkg::CMD_PSUM) |=> in_ready)
    else $error("block busy after a load request");

  // A partial-sum request occupies the sequencer.
  a_psum_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == cv3_pkg::CMD_PSUM) |=> !in_ready)
    else $error("request taken while a partial sum is in work");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind conv3x3_same_zero_pad_top cv3_chk u_cv3_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_command   (in_ch.command),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_position (out_ch.out_position),
  .out_value    (out_ch.out_value)
);
